@@ rtl/etx_pkg.sv @@
`default_nettype none
package etx_pkg;

    localparam int unsigned MAX_TERMS  = 32;
    localparam int unsigned TERM_W     = 6;
    localparam int unsigned ARG_W      = 32;
    localparam int unsigned SUM_W      = 64;
    localparam int unsigned MAG_W      = 63;
    localparam int unsigned DIV_BITS   = 8;
    localparam int unsigned DIV_STAGES = 9;
    localparam int unsigned DIV_W      = DIV_BITS * DIV_STAGES;
    // add stage, two multiply stages, divider stages
    localparam int unsigned RING_DEPTH = 3 + DIV_STAGES;

    localparam logic [TERM_W-1:0] NUM_TERMS_RST = TERM_W'(20);
    localparam logic [MAG_W-1:0]  MAG_ONE       = MAG_W'(64'h1_0000_0000);
    localparam logic [MAG_W-1:0]  MAG_MAX       = {MAG_W{1'b1}};

    typedef struct packed {
        logic              valid;
        logic              xneg;
        logic [ARG_W-1:0]  ax;
        logic              neg;
        logic [MAG_W-1:0]  mag;
        logic [SUM_W-1:0]  sum;
        logic              ovf;
        logic [TERM_W-1:0] k;
        logic [TERM_W-1:0] n;
    } t_tok;

endpackage
`default_nettype wire

@@ rtl/etx_mul.sv @@
`default_nettype none
module etx_mul (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  etx_pkg::t_tok           i_tok,
    output etx_pkg::t_tok           o_tok,
    output logic [etx_pkg::DIV_W-1:0] o_dividend
);
    import etx_pkg::*;

    t_tok              r_tok1;
    logic [62:0]       r_phi;
    logic [63:0]       r_plo;
    t_tok              r_tok2;
    logic [DIV_W-1:0]  r_w;
    logic [62:0]       n_a;

    // |term| * |x| as two partial products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok1 <= '0;
        end else begin
            r_tok1 <= i_tok;
        end
        r_phi <= 63'({31'd0, i_tok.mag[62:32]} * {31'd0, i_tok.ax});
        r_plo <= {32'd0, i_tok.mag[31:0]} * {32'd0, i_tok.ax};
    end

    assign n_a = r_phi + {31'd0, r_plo[63:32]};

    // product >> 27, laid out for the long division
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok2 <= '0;
        end else begin
            r_tok2 <= r_tok1;
        end
        r_w <= {(DIV_W - 68)'(0), n_a, r_plo[31:27]};
    end

    assign o_tok      = r_tok2;
    assign o_dividend = r_w;
endmodule
`default_nettype wire

@@ rtl/etx_div_stage.sv @@
`default_nettype none
module etx_div_stage (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  etx_pkg::t_tok              i_tok,
    input  wire [etx_pkg::DIV_W-1:0]   i_w,
    input  wire [etx_pkg::TERM_W-1:0]  i_rem,
    output etx_pkg::t_tok              o_tok,
    output logic [etx_pkg::DIV_W-1:0]  o_w,
    output logic [etx_pkg::TERM_W-1:0] o_rem
);
    import etx_pkg::*;

    t_tok              r_tok;
    logic [DIV_W-1:0]  r_w;
    logic [TERM_W-1:0] r_rem;
    logic [DIV_W-1:0]  n_w;
    logic [TERM_W-1:0] n_rem;
    logic [TERM_W:0]   trial;
    logic [TERM_W:0]   divisor;

    // divisor is the index of the term being formed
    assign divisor = {1'b0, i_tok.k} + (TERM_W+1)'(1);

    // restoring division, one quotient bit per step, bits shift in at the bottom
    always_comb begin
        n_w   = i_w;
        n_rem = i_rem;
        trial = '0;
        for (int s = 0; s < DIV_BITS; s++) begin
            trial = {n_rem, n_w[DIV_W-1]};
            if (trial >= divisor) begin
                trial = trial - divisor;
                n_w   = {n_w[DIV_W-2:0], 1'b1};
            end else begin
                n_w   = {n_w[DIV_W-2:0], 1'b0};
            end
            n_rem = trial[TERM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= i_tok;
        end
        r_w   <= n_w;
        r_rem <= n_rem;
    end

    assign o_tok = r_tok;
    assign o_w   = r_w;
    assign o_rem = r_rem;
endmodule
`default_nettype wire

@@ rtl/exp_taylor_series_core.sv @@
`default_nettype none
// Truncated Taylor sum of e^x, x in Q5.27, result in Q31.32 with saturation.
// Input: drive i_arg_x with i_start high; the item is taken at a clock edge
// where o_busy is low. Result: o_valid is high for one cycle with o_exp_sum
// and o_overflow; the receiver cannot hold it off.
// i_cfg_we / i_cfg_data write the term count n (0 acts as 1); each item
// samples it on entry.
// Terms circulate around a 12-stage ring: one add stage, two multiply stages
// and nine long-division stages of eight quotient bits each. Each term after
// the first takes one trip around the ring before o_valid.
// Up to 12 items share the ring; o_busy is high when a circulating term
// claims the entry slot, so a new item is taken only into a slot that no
// circulating term holds.
// Reset empties the ring and sets n to 20.
module exp_taylor_series_core (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_start,
    output logic                              o_busy,
    input  wire signed [etx_pkg::ARG_W-1:0]   i_arg_x,
    input  wire                               i_cfg_we,
    input  wire [etx_pkg::TERM_W-1:0]         i_cfg_data,
    output logic                              o_valid,
    output logic signed [etx_pkg::SUM_W-1:0]  o_exp_sum,
    output logic                              o_overflow
);
    import etx_pkg::*;

    logic [TERM_W-1:0] r_num_terms;
    t_tok              r_add;
    t_tok              n_add;
    logic              r_done;
    t_tok              new_tok, re_tok, src, mul_in, mul_tok;
    logic [DIV_W-1:0]  mul_w;
    logic [TERM_W-1:0] n_clamped;
    logic              accept;
    logic [SUM_W-1:0]  term;
    logic [SUM_W:0]    s65;
    logic              add_ovf;
    logic [DIV_W-1:0]  q;
    logic              q_sat;
    logic [MAG_W-1:0]  q_mag;

    t_tok              d_tok [DIV_STAGES+1];
    logic [DIV_W-1:0]  d_w   [DIV_STAGES+1];
    logic [TERM_W-1:0] d_rem [DIV_STAGES+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_terms <= NUM_TERMS_RST;
        end else if (i_cfg_we) begin
            r_num_terms <= i_cfg_data;
        end
    end

    assign o_busy = d_tok[DIV_STAGES].valid;
    assign accept = i_start && !o_busy;

    always_comb begin
        if (r_num_terms == '0) begin
            n_clamped = TERM_W'(1);
        end else if ({1'b0, r_num_terms} > (TERM_W+1)'(MAX_TERMS)) begin
            n_clamped = TERM_W'(MAX_TERMS);
        end else begin
            n_clamped = r_num_terms;
        end
    end

    always_comb begin
        new_tok       = '0;
        new_tok.valid = accept;
        new_tok.xneg  = i_arg_x[ARG_W-1];
        new_tok.ax    = i_arg_x[ARG_W-1] ? (~i_arg_x + ARG_W'(1)) : i_arg_x;
        new_tok.mag   = MAG_ONE;
        new_tok.n     = n_clamped;
    end

    // finish the term leaving the divider: saturate, sign, advance index
    assign q     = d_w[DIV_STAGES];
    assign q_sat = |q[DIV_W-1:MAG_W];
    assign q_mag = q_sat ? MAG_MAX : q[MAG_W-1:0];

    always_comb begin
        re_tok     = d_tok[DIV_STAGES];
        re_tok.mag = q_mag;
        re_tok.neg = (q_mag != '0) && (d_tok[DIV_STAGES].neg != d_tok[DIV_STAGES].xneg);
        re_tok.ovf = d_tok[DIV_STAGES].ovf || q_sat;
        re_tok.k   = d_tok[DIV_STAGES].k + TERM_W'(1);
    end

    assign src = d_tok[DIV_STAGES].valid ? re_tok : new_tok;

    // saturating accumulate
    assign term    = src.neg ? (~{1'b0, src.mag} + SUM_W'(1)) : {1'b0, src.mag};
    assign s65     = {src.sum[SUM_W-1], src.sum} + {term[SUM_W-1], term};
    assign add_ovf = s65[SUM_W] != s65[SUM_W-1];

    always_comb begin
        n_add = src;
        if (add_ovf) begin
            n_add.sum = term[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}}
                                      : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            n_add.sum = s65[SUM_W-1:0];
        end
        n_add.ovf = src.ovf || add_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_add  <= '0;
            r_done <= 1'b0;
        end else begin
            r_add  <= n_add;
            r_done <= ({1'b0, src.k} + (TERM_W+1)'(1)) >= {1'b0, src.n};
        end
    end

    assign o_valid    = r_add.valid && r_done;
    assign o_exp_sum  = r_add.sum;
    assign o_overflow = r_add.ovf;

    // drop the item from the ring once its last term is summed
    always_comb begin
        mul_in       = r_add;
        mul_in.valid = r_add.valid && !r_done;
    end

    etx_mul u_mul (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tok      (mul_in),
        .o_tok      (mul_tok),
        .o_dividend (mul_w)
    );

    assign d_tok[0] = mul_tok;
    assign d_w[0]   = mul_w;
    assign d_rem[0] = '0;

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        etx_div_stage u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (d_tok[g]),
            .i_w     (d_w[g]),
            .i_rem   (d_rem[g]),
            .o_tok   (d_tok[g+1]),
            .o_w     (d_w[g+1]),
            .o_rem   (d_rem[g+1])
        );
    end
endmodule
`default_nettype wire

@@ rtl/etx_checker.sv @@
`default_nettype none
module etx_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire i_start,
    input wire o_busy,
    input wire o_valid
);
    import etx_pkg::*;

    logic [4:0] r_cnt;

    // items taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 5'(i_start && !o_busy) - 5'(o_valid);
        end
    end

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_busy)
        else $error("result or busy right after reset");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_cnt != '0)
        else $error("result without an item in flight");

    a_ring_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 5'(RING_DEPTH))
        else $error("more items in flight than ring slots");
endmodule

bind exp_taylor_series_core etx_checker u_etx_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_valid (o_valid)
);
`default_nettype wire

@@ dv/exp_taylor_series_core_tb.sv @@
`default_nettype none
module exp_taylor_series_core_tb;
    import etx_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_500_000;
    // worst latency, with MAX_TERMS terms, plus margin
    localparam int unsigned SETTLE = 420;

    typedef struct {
        logic [SUM_W-1:0] sum;
        logic             ovf;
    } t_exp_result;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_start = 1'b0;
    logic signed [ARG_W-1:0]  i_arg_x = '0;
    logic                     i_cfg_we = 1'b0;
    logic [TERM_W-1:0]        i_cfg_data = '0;
    wire                      o_busy;
    wire                      o_valid;
    wire signed [SUM_W-1:0]   o_exp_sum;
    wire                      o_overflow;

    t_exp_result       exp_result_q[$];
    logic [TERM_W-1:0] term_count = NUM_TERMS_RST;
    int unsigned       fail_cnt = 0;
    int unsigned       cycle_cnt = 0;
    bit                idle_on = 1'b1;

    exp_taylor_series_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_arg_x    (i_arg_x),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_exp_sum  (o_exp_sum),
        .o_overflow (o_overflow)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_exp_result taylor_exp(logic [ARG_W-1:0] x, logic [TERM_W-1:0] cfg);
        t_exp_result res;
        logic [63:0] ax, mag, ph, pl, a, r5, q1, r1, q2, d, n;
        longint      acc, t;
        bit          xneg, neg, ovf;
        xneg = x[ARG_W-1];
        ax   = xneg ? ((64'h1_0000_0000 - 64'(x)) & 64'hFFFF_FFFF) : 64'(x);
        if (xneg && ax == 0) begin
            ax = 64'h8000_0000;
        end
        n = (cfg < 1) ? 1 : ((cfg > MAX_TERMS) ? MAX_TERMS : 64'(cfg));
        mag = 64'h1_0000_0000;
        neg = 1'b0;
        ovf = 1'b0;
        acc = 0;
        for (int unsigned k = 0; k < n; k++) begin
            t = neg ? -longint'(mag) : longint'(mag);
            if (t > 0 && acc > 64'sh7FFF_FFFF_FFFF_FFFF - t) begin
                acc = 64'sh7FFF_FFFF_FFFF_FFFF;
                ovf = 1'b1;
            end else if (t < 0 && acc < 64'sh8000_0000_0000_0000 - t) begin
                acc = 64'sh8000_0000_0000_0000;
                ovf = 1'b1;
            end else begin
                acc = acc + t;
            end
            if (k + 1 < n) begin
                // full-width product, then divide by 2^27 * (k+1)
                d  = k + 1;
                ph = (mag >> 32) * ax;
                pl = (mag & 64'hFFFF_FFFF) * ax;
                a  = ph + (pl >> 32);
                r5 = (pl & 64'hFFFF_FFFF) >> 27;
                q1 = a / d;
                r1 = a % d;
                q2 = (r1 * 32 + r5) / d;
                if (q1 >= 64'h0400_0000_0000_0000) begin
                    ovf = 1'b1;
                    mag = 64'h7FFF_FFFF_FFFF_FFFF;
                end else begin
                    mag = (q1 << 5) + q2;
                end
                neg = (mag != 0) && (neg != xneg);
            end
        end
        res.sum = acc;
        res.ovf = ovf;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_exp_result want;
        if (i_rst_n && o_valid) begin
            if (exp_result_q.size() == 0) begin
                $error("result with no item pending: exp_sum %h", o_exp_sum);
                fail_cnt++;
            end else begin
                want = exp_result_q.pop_front();
                if (o_exp_sum !== want.sum) begin
                    $error("exp_sum: expected %h, got %h", want.sum, o_exp_sum);
                    fail_cnt++;
                end
                if (o_overflow !== want.ovf) begin
                    $error("overflow: expected %b, got %b", want.ovf, o_overflow);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_arg(logic [ARG_W-1:0] x);
        // idle each cycle with a fixed chance
        while (idle_on && $urandom_range(99) < 26) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_arg_x <= x;
        do @(posedge i_clk); while (o_busy);
        exp_result_q.push_back(taylor_exp(x, term_count));
    endtask

    // drop start, drain all results, then let the ring empty
    task automatic drain();
        i_start <= 1'b0;
        while (exp_result_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_terms(logic [TERM_W-1:0] v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        term_count = v;
    endtask

    function automatic logic [ARG_W-1:0] rand_arg();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return ARG_W'($signed($urandom_range(0, 2 ** 30)) - 2 ** 29);
            2:       return ARG_W'($signed($urandom_range(0, 2 ** 28)) - 2 ** 27);
            default: return ARG_W'($signed($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    task automatic test_default_terms();
        send_arg(32'h0800_0000);
        send_arg(32'h0000_0000);
        send_arg(32'hF800_0000);
    endtask

    task automatic test_term_extremes();
        logic [TERM_W-1:0] counts[5] = '{6'd0, 6'd1, 6'd32, 6'd33, 6'd63};
        foreach (counts[i]) begin
            write_terms(counts[i]);
            send_arg(32'h7FFF_FFFF);
            send_arg(32'h8000_0000);
            send_arg(32'h0800_0000);
        end
    endtask

    task automatic test_directed_args();
        logic [ARG_W-1:0] args[12] = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
            32'h7FFF_FFFF, 32'h8000_0000, 32'h0800_0000, 32'hF800_0000,
            32'h1000_0000, 32'hE000_0000, 32'h0000_0010, 32'h5555_5555, 32'hAAAA_AAAA};
        write_terms(6'd32);
        foreach (args[i]) send_arg(args[i]);
        write_terms(6'd2);
        foreach (args[i]) send_arg(args[i]);
    endtask

    task automatic test_random();
        for (int p = 0; p < 8; p++) begin
            write_terms((p == 0) ? 6'd32 : 6'($urandom_range(0, 63)));
            // one phase with steady back-to-back items
            idle_on = (p != 3);
            repeat (100) send_arg(rand_arg());
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_terms();
        test_term_extremes();
        test_directed_args();
        test_random();
        drain();
        if (fail_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ filelist.f @@
rtl/etx_pkg.sv
rtl/etx_mul.sv
rtl/etx_div_stage.sv
rtl/exp_taylor_series_core.sv
rtl/etx_checker.sv
dv/exp_taylor_series_core_tb.sv
